[rtl/sha_pkg.sv]
// Shared types, constants and round functions for the SHA-256 hasher.
package sha_pkg;

  localparam int unsigned QDepth = 4;
  localparam int unsigned QAw = $clog2(QDepth);

  // Word handed from the byte front end to the compression back end.
  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } sha_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PAD,
    ST_LEN,
    ST_ROUND,
    ST_ADD,
    ST_OUT
  } sha_state_e;

  localparam logic [7:0] PadByte = 8'h80;

  localparam logic [31:0] InitH [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam logic [31:0] RoundK [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic logic [31:0] small_sig0(input logic [31:0] x);
    small_sig0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic logic [31:0] small_sig1(input logic [31:0] x);
    small_sig1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic logic [31:0] big_sig0(input logic [31:0] x);
    big_sig0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic logic [31:0] big_sig1(input logic [31:0] x);
    big_sig1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

endpackage

[rtl/sha_queue.sv]
// Short word queue between the byte front end and the compression back end.
module sha_queue
  import sha_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      wr_valid_i,
  output logic      wr_ready_o,
  input  sha_item_t wr_item_i,
  output logic      rd_valid_o,
  input  logic      rd_ready_i,
  output sha_item_t rd_item_o
);

  sha_item_t        mem_q [QDepth];
  logic [QAw-1:0]   wp_q, rp_q;
  logic [QAw:0]     cnt_q;
  logic             push, pop;

  assign wr_ready_o = (cnt_q != (QAw+1)'(QDepth));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_item_o  = mem_q[rp_q];
  assign push = wr_valid_i && wr_ready_o;
  assign pop  = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) mem_q[wp_q] <= wr_item_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= '0;
      rp_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push) wp_q <= wp_q + 1'b1;
      if (pop)  rp_q <= rp_q + 1'b1;
      cnt_q <= cnt_q + (QAw+1)'(push) - (QAw+1)'(pop);
    end
  end

endmodule

[rtl/sha_core.sv]
// Back end: block assembly, padding, 64-round compression and digest output.
module sha_core
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  sha_item_t   in_item_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha_state_e  state_q, state_d;
  logic [31:0] h_q [8];
  logic [31:0] v_q [8];
  logic [31:0] w_q [16];   // sliding schedule window, also the block buffer
  logic [5:0]  fill_q;
  logic [63:0] len_q;
  logic [5:0]  rnd_q;
  logic        final_q;    // block being compressed ends the message
  logic        pend_q;     // message closed on the byte that filled the block
  logic [2:0]  oidx_q;

  logic        take;
  logic [5:0]  fill_n;
  logic [31:0] w_new, t1, t2;

  assign in_ready_o    = (state_q == ST_IDLE);
  assign take          = in_valid_i && in_ready_o;
  assign fill_n        = fill_q + 6'd1;
  assign out_valid_o   = (state_q == ST_OUT);
  assign digest_word_o = h_q[oidx_q];
  assign word_index_o  = oidx_q;
  assign last_word_o   = (oidx_q == 3'd7);

  assign w_new = small_sig1(w_q[14]) + w_q[9] + small_sig0(w_q[1]) + w_q[0];
  assign t1 = v_q[7] + big_sig1(v_q[4]) + ((v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]))
            + RoundK[rnd_q] + w_q[0];
  assign t2 = big_sig0(v_q[0]) + ((v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]));

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (in_item_i.has_byte && fill_n == 6'd0) state_d = ST_ROUND;
          else if (in_item_i.last) state_d = ST_PAD;
        end
      end
      ST_PAD: begin
        if (fill_q >= 6'd56) state_d = ST_ROUND;
        else state_d = ST_LEN;
      end
      ST_LEN:   state_d = ST_ROUND;
      ST_ROUND: if (rnd_q == 6'd63) state_d = ST_ADD;
      ST_ADD: begin
        if (final_q) state_d = ST_OUT;
        else if (fill_q != 6'd0) state_d = ST_LEN;   // pad spilled into a second block
        else if (pend_q) state_d = ST_PAD;           // pad goes into a fresh block
        else state_d = ST_IDLE;
      end
      ST_OUT: if (out_ready_i && oidx_q == 3'd7) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      h_q     <= InitH;
      fill_q  <= '0;
      len_q   <= '0;
      rnd_q   <= '0;
      final_q <= 1'b0;
      pend_q  <= 1'b0;
      oidx_q  <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          rnd_q <= '0;
          v_q   <= h_q;
          if (take) begin
            final_q <= in_item_i.last;
            pend_q  <= 1'b0;
            if (in_item_i.has_byte) begin
              w_q[fill_q[5:2]][8*(3-fill_q[1:0]) +: 8] <= in_item_i.data;
              fill_q <= fill_n;
              len_q  <= len_q + 64'd8;
              if (fill_n == 6'd0) begin
                final_q <= 1'b0;
                pend_q  <= in_item_i.last;
              end
            end
          end
        end
        ST_PAD: begin
          // append the marker byte and zero the rest of its word and block
          pend_q <= 1'b0;
          for (int i = 0; i < 16; i++) begin
            if (4'(i) > fill_q[5:2]) w_q[i] <= '0;
          end
          for (int b = 0; b < 4; b++) begin
            if (2'(b) == fill_q[1:0]) w_q[fill_q[5:2]][8*(3-b) +: 8] <= PadByte;
            else if (2'(b) > fill_q[1:0]) w_q[fill_q[5:2]][8*(3-b) +: 8] <= 8'h00;
          end
          if (fill_q >= 6'd56) begin
            final_q <= 1'b0;
            fill_q  <= 6'd1;   // marks a second, length-only block
          end else begin
            fill_q <= '0;
          end
        end
        ST_LEN: begin
          if (fill_q != 6'd0) begin
            for (int i = 0; i < 14; i++) w_q[i] <= '0;
          end
          w_q[14] <= len_q[63:32];
          w_q[15] <= len_q[31:0];
          fill_q  <= '0;
          final_q <= 1'b1;
          v_q     <= h_q;
          rnd_q   <= '0;
        end
        ST_ROUND: begin
          v_q[7] <= v_q[6];
          v_q[6] <= v_q[5];
          v_q[5] <= v_q[4];
          v_q[4] <= v_q[3] + t1;
          v_q[3] <= v_q[2];
          v_q[2] <= v_q[1];
          v_q[1] <= v_q[0];
          v_q[0] <= t1 + t2;
          for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
          w_q[15] <= w_new;
          rnd_q <= rnd_q + 6'd1;
        end
        ST_ADD: begin
          for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
          oidx_q <= '0;
          v_q <= v_q;
        end
        ST_OUT: begin
          if (out_ready_i) begin
            oidx_q <= oidx_q + 3'd1;
            if (oidx_q == 3'd7) begin
              h_q    <= InitH;
              len_q  <= '0;
              fill_q <= '0;
            end
          end
        end
        default: ;
      endcase
    end
  end

endmodule

[rtl/sha256_hasher_top.sv]
// Top level of the SHA-256 hasher: byte queue in front of the compression core.
//
// Input channel: one word per item carrying data_byte_i, has_byte_i and last_i,
// under valid_i/ready_o. A word with has_byte_i appends a byte; a word with
// last_i closes the message (an empty message is allowed).
// Output channel: eight digest words, index 0 first, last_word_o on index 7,
// under out_valid_o/out_ready_i.
// The core takes byte words only while idle; a four-deep queue absorbs
// bursts. Every 64th byte starts the round loop and then the chaining add,
// during which the core takes no bytes; the sustained rate is set by the
// single shared round unit. A closing word adds one or two blocks of
// padding before the digest.
// Reset loads the initial hash values and clears length and fill count.
// While the receiver stalls the digest words hold, the core stops, and the
// queue fills and then drops ready_o.
module sha256_hasher_top
  import sha_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        ready_o,
  input  logic [7:0]  data_byte_i,
  input  logic        has_byte_i,
  input  logic        last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] digest_word_o,
  output logic [2:0]  word_index_o,
  output logic        last_word_o
);

  sha_item_t in_item, q_item;
  logic      q_valid, q_ready;

  assign in_item = '{data: data_byte_i, has_byte: has_byte_i, last: last_i};

  sha_queue u_queue (
    .clk_i, .rst_ni,
    .wr_valid_i (valid_i),
    .wr_ready_o (ready_o),
    .wr_item_i  (in_item),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_item_o  (q_item)
  );

  sha_core u_core (
    .clk_i, .rst_ni,
    .in_valid_i   (q_valid),
    .in_ready_o   (q_ready),
    .in_item_i    (q_item),
    .out_valid_o,
    .out_ready_i,
    .digest_word_o,
    .word_index_o,
    .last_word_o
  );

endmodule

[verif/tb.sv]
// Testbench for sha256_hasher_top: byte-stream messages checked against a SHA-256 predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sha_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        valid_i = 1'b0;
  logic        ready_o;
  logic [7:0]  data_byte_i = 8'h00;
  logic        has_byte_i = 1'b0;
  logic        last_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic [31:0] digest_word_o;
  logic [2:0]  word_index_o;
  logic        last_word_o;

  sha256_hasher_top uut (.*);

  always #6 clk_i = ~clk_i;

  typedef struct {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_t;

  typedef struct {
    logic [7:0] data;
    logic       has;
    logic       fin;
    logic       check_w0;
    logic [31:0] w0;
  } stim_t;

  // predictor state
  logic [31:0] chain [8];
  logic [7:0]  blk [64];
  logic [5:0]  fill;
  logic [63:0] nbits;

  digest_t digest_q [$];
  logic [31:0] pinned_q [$];
  logic        pinned_chk_q [$];
  int errors = 0;
  int digests_seen = 0;
  int messages = 0;
  int cycles = 0;
  int n_items = 0;
  bit stim_done = 1'b0;
  bit long_stall = 1'b0;

  localparam logic [31:0] K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };
  localparam logic [31:0] IV [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  function automatic logic [31:0] ror(logic [31:0] x, int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
    for (int t = 16; t < 64; t++)
      w[t] = w[t-16] + w[t-7]
           + (ror(w[t-15], 7) ^ ror(w[t-15], 18) ^ (w[t-15] >> 3))
           + (ror(w[t-2], 17) ^ ror(w[t-2], 19) ^ (w[t-2] >> 10));
    v = chain;
    for (int t = 0; t < 64; t++) begin
      t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K[t] + w[t];
      t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) chain[i] += v[i];
  endtask

  task automatic hash_clear();
    chain = IV;
    fill = '0;
    nbits = '0;
  endtask

  // advance predictor by one accepted word, queue digest on close
  task automatic hash_word(logic [7:0] d, logic has, logic fin);
    if (has) begin
      blk[fill] = d;
      nbits += 64'd8;
      fill += 6'd1;
      if (fill == 6'd0) compress();
    end
    if (fin) begin
      blk[fill] = PadByte;
      if (fill >= 6'd56) begin
        for (int j = fill + 1; j < 64; j++) blk[j] = 8'h00;
        compress();
        for (int j = 0; j < 56; j++) blk[j] = 8'h00;
      end else begin
        for (int j = fill + 1; j < 56; j++) blk[j] = 8'h00;
      end
      for (int j = 0; j < 8; j++) blk[56+j] = nbits[63-8*j -: 8];
      compress();
      for (int j = 0; j < 8; j++) digest_q.push_back('{chain[j], 3'(j), j == 7});
      messages++;
      hash_clear();
    end
  endtask

  task automatic send(logic [7:0] d, logic has, logic fin);
    data_byte_i <= d;
    has_byte_i <= has;
    last_i <= fin;
    valid_i <= 1'b1;
    @(posedge clk_i);
    while (!ready_o) @(posedge clk_i);
    hash_word(d, has, fin);
    n_items++;
    // short gaps mostly, a few long ones; no gap at all half the time
    if ($urandom_range(1, 0) == 1) begin
      valid_i <= 1'b0;
      repeat ($urandom_range(9, 0) == 0 ? $urandom_range(60, 10) : $urandom_range(3, 1))
        @(posedge clk_i);
    end
  endtask

  task automatic send_msg(int len);
    for (int i = 0; i < len; i++)
      send(8'($urandom), 1'b1, (i == len - 1) && $urandom_range(1, 0));
    if (len == 0 || !last_i) send(8'($urandom), 1'b0, 1'b1);
  endtask

  stim_t dir_rows [10] = '{
    '{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442},   // empty message
    '{8'h61, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h62, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf},   // "abc" with byte on close
    '{8'h00, 1'b0, 1'b0, 1'b0, 32'h0},          // no-op word
    '{8'hff, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h00, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'h5a, 1'b0, 1'b0, 1'b0, 32'h0},
    '{8'ha5, 1'b1, 1'b0, 1'b0, 32'h0},
    '{8'hff, 1'b0, 1'b1, 1'b0, 32'h0}           // close without byte
  };

  // output side: random stalls, one long hold-off
  always @(posedge clk_i) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (long_stall) out_ready_i <= 1'b0;
    else out_ready_i <= ($urandom_range(7, 0) != 0) ||
                        ($urandom_range(15, 0) == 0 ? 1'b0 : 1'b1) && $urandom_range(1, 0);
  end

  always @(posedge clk_i) begin
    digest_t exp_d;
    cycles <= cycles + 1;
    if (rst_ni && out_valid_o && out_ready_i) begin
      digests_seen++;
      if (digest_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected digest word %h idx %0d", digest_word_o, word_index_o);
      end else begin
        exp_d = digest_q.pop_front();
        if (exp_d.idx == 3'd0 && pinned_q.size() > 0) begin
          if (pinned_chk_q.pop_front() && pinned_q[0] != digest_word_o) begin
            errors++;
            if (errors <= 10) $display("known digest mismatch: exp %h got %h",
                                       pinned_q[0], digest_word_o);
          end
          void'(pinned_q.pop_front());
        end
        if (exp_d.word !== digest_word_o || exp_d.idx !== word_index_o ||
            exp_d.fin !== last_word_o) begin
          errors++;
          if (errors <= 10)
            $display("digest mismatch: exp %h/%0d/%b got %h/%0d/%b", exp_d.word, exp_d.idx,
                     exp_d.fin, digest_word_o, word_index_o, last_word_o);
        end
      end
    end
  end

  initial begin
    hash_clear();
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].fin) begin
        pinned_q.push_back(dir_rows[i].w0);
        pinned_chk_q.push_back(dir_rows[i].check_w0);
      end
      send(dir_rows[i].data, dir_rows[i].has, dir_rows[i].fin);
    end
    // block edges: pad spilling into a second block, and a full 64-byte block
    send_msg(56);
    send_msg(64);

    // pause until all digest words have drained
    valid_i <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk_i);

    // hold the receiver off while bytes keep coming so the input backs up
    long_stall = 1'b1;
    fork
      begin
        repeat (400) @(posedge clk_i);
        long_stall = 1'b0;
      end
      begin
        send_msg(12);
        send_msg(8);
      end
    join

    while (n_items < 190) begin
      int n;
      n = $urandom_range(12, 0);
      if ($urandom_range(4, 0) == 0) send(8'($urandom), 1'b0, 1'b0);
      send_msg(n);
    end
    valid_i <= 1'b0;
    stim_done = 1'b1;
  end

  initial begin
    wait (stim_done);
    while (digest_q.size() != 0) @(posedge clk_i);
    repeat (200) @(posedge clk_i);
    $display("checked %0d messages, %0d digest words, incl. padding edges and input backpressure",
             messages, digests_seen);
    if (errors == 0 && digest_q.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  initial begin
    wait (cycles > 400000);
    $display("timeout after %0d cycles", cycles);
    $display("TB_ERROR");
    $finish;
  end

endmodule

[files.f]
rtl/sha_pkg.sv
rtl/sha_queue.sv
rtl/sha_core.sv
rtl/sha256_hasher_top.sv
verif/tb.sv
